/* sv/bbfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbfa_pkg: shared types and constants
// Codes, widths and controller/datapath command and status words.
// ----------------------------------------------------------------------------
package bbfa_pkg;
   localparam int MaxBlocks  = 1024;
   localparam int WordBits   = 8;
   localparam int MapWords   = MaxBlocks / WordBits;
   localparam int IdxW       = 10;
   localparam int CntW       = 11;
   localparam int AddrW      = 7;
   localparam int LaneW      = 3;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_TEST    = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   typedef struct packed {
      logic load;      // capture request, reset scan position
      logic scan;      // examine one block of the map
      logic scan_end;  // close the last run
      logic mark;      // write one block at the walk position
      logic mark_val;  // value written by mark
      logic wipe;      // zero one map word
      logic finish;    // drive result
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       scan_done;
      logic       walk_done;
      logic       wipe_done;
      logic       found;
      logic       fit_ok;
   } stat_type;
endpackage
`default_nettype wire

/* sv/bbfa_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbfa_datapath: map store and run tracker
// Bit-addressed walk over the word store, best-fit bookkeeping, result regs.
// ----------------------------------------------------------------------------
module bbfa_datapath (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_write,
   input  wire [bbfa_pkg::CntW-1:0]      csr_data,
   input  wire [1:0]                     req_operation,
   input  wire [bbfa_pkg::IdxW-1:0]      req_block_index,
   input  wire [bbfa_pkg::CntW-1:0]      req_block_total,
   input  wire bbfa_pkg::cmd_type        cmd,
   output bbfa_pkg::stat_type            stat,
   output logic                          rsp_valid,
   output logic                          rsp_success,
   output logic [bbfa_pkg::IdxW-1:0]     rsp_start_block,
   output logic                          rsp_bit_used
);
   logic [bbfa_pkg::WordBits-1:0] map_mem [bbfa_pkg::MapWords];
   logic [bbfa_pkg::MapWords-1:0] map_vld_ff;
   logic [bbfa_pkg::CntW-1:0] len_ff, len_in;
   logic [1:0] op_ff;
   logic [bbfa_pkg::IdxW-1:0] idx_ff;
   logic [bbfa_pkg::CntW-1:0] cnt_ff;
   logic [bbfa_pkg::CntW-1:0] pos_ff, pos_in;
   logic [bbfa_pkg::CntW-1:0] run_start_ff, run_size_ff;
   logic [bbfa_pkg::CntW-1:0] pick_start_ff, pick_size_ff;
   logic found_ff, in_run_ff;
   logic [bbfa_pkg::CntW-1:0] walk_ff;
   logic [bbfa_pkg::AddrW-1:0] wipe_ff;
   logic [bbfa_pkg::WordBits-1:0] rd_data_ff;
   logic rd_vld_ff;
   logic [bbfa_pkg::WordBits-1:0] rd_word, wr_word;
   logic [bbfa_pkg::AddrW-1:0] rd_addr, fetch_addr;
   logic [bbfa_pkg::LaneW-1:0] rd_lane;
   logic [bbfa_pkg::CntW-1:0] bit_pos;
   logic cur_bit, close_run, fits, mark_en;
   logic [bbfa_pkg::CntW-1:0] run_len;
   logic [bbfa_pkg::CntW:0] rel_pos;

   assign len_in = (csr_data > bbfa_pkg::CntW'(bbfa_pkg::MaxBlocks))
      ? bbfa_pkg::CntW'(bbfa_pkg::MaxBlocks) : csr_data;

   // walk position: scan uses pos, mark uses start + walk
   always_comb begin
      rel_pos = '0;
      if (cmd.scan) begin
         bit_pos = pos_ff;
      end else if (op_ff == bbfa_pkg::OP_ALLOC) begin
         bit_pos = pick_start_ff + walk_ff;
      end else if (op_ff == bbfa_pkg::OP_RELEASE) begin
         rel_pos = {2'b00, idx_ff} + {1'b0, walk_ff};
         bit_pos = rel_pos[bbfa_pkg::CntW-1:0];
      end else begin
         bit_pos = {1'b0, idx_ff};
      end
   end
   assign rd_addr = bit_pos[bbfa_pkg::IdxW-1:bbfa_pkg::LaneW];
   assign rd_lane = bit_pos[bbfa_pkg::LaneW-1:0];
   // prefetch the next scan word while scanning, else the word at the walk position
   assign fetch_addr = cmd.scan ? pos_in[bbfa_pkg::IdxW-1:bbfa_pkg::LaneW] : rd_addr;
   assign rd_word = rd_vld_ff ? rd_data_ff : '0;
   assign cur_bit = rd_word[rd_lane];

   always_comb begin
      wr_word = rd_word;
      wr_word[rd_lane] = cmd.mark_val;
   end
   assign mark_en = cmd.mark && !rel_pos[bbfa_pkg::CntW] && (bit_pos < len_ff);

   assign close_run = (cmd.scan && cur_bit && in_run_ff) || (cmd.scan_end && in_run_ff);
   assign run_len = run_size_ff;
   assign fits = (run_len >= cnt_ff) && (!found_ff || run_len < pick_size_ff);

   always_ff @(posedge clock) begin
      rd_data_ff <= map_mem[fetch_addr];
      rd_vld_ff <= map_vld_ff[fetch_addr];
      if (mark_en) begin
         map_mem[rd_addr] <= wr_word;
      end
      if (cmd.wipe) begin
         map_mem[wipe_ff] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
         len_ff <= bbfa_pkg::CntW'(bbfa_pkg::MaxBlocks);
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write) len_ff <= len_in;
         if (mark_en) map_vld_ff[rd_addr] <= 1'b1;
         if (cmd.wipe) map_vld_ff[wipe_ff] <= 1'b0;
         rsp_valid <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load) begin
         op_ff <= req_operation;
         idx_ff <= req_block_index;
         cnt_ff <= req_block_total;
         found_ff <= 1'b0;
         in_run_ff <= 1'b0;
         run_size_ff <= '0;
         walk_ff <= '0;
         wipe_ff <= '0;
         pick_start_ff <= '0;
         pick_size_ff <= '0;
      end else begin
         if (close_run && fits) begin
            found_ff <= 1'b1;
            pick_start_ff <= run_start_ff;
            pick_size_ff <= run_len;
         end
         if (cmd.scan) begin
            if (cur_bit) begin
               in_run_ff <= 1'b0;
            end else begin
               if (!in_run_ff) begin
                  run_start_ff <= pos_ff;
                  run_size_ff <= bbfa_pkg::CntW'(1);
               end else begin
                  run_size_ff <= run_size_ff + 1'b1;
               end
               in_run_ff <= 1'b1;
            end
         end
         if (cmd.scan_end) in_run_ff <= 1'b0;
         if (cmd.mark) walk_ff <= walk_ff + 1'b1;
         if (cmd.wipe) wipe_ff <= wipe_ff + 1'b1;
      end
      if (cmd.finish) begin
         rsp_success <= (op_ff != bbfa_pkg::OP_ALLOC) || found_ff;
         rsp_start_block <= (op_ff == bbfa_pkg::OP_ALLOC && found_ff)
            ? pick_start_ff[bbfa_pkg::IdxW-1:0] : '0;
         rsp_bit_used <= (op_ff == bbfa_pkg::OP_TEST) && ({1'b0, idx_ff} < len_ff) && cur_bit;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) pos_in = '0;
      else if (cmd.scan) pos_in = pos_ff + 1'b1;
   end

   assign stat.op = op_ff;
   assign stat.scan_done = (pos_ff >= len_ff);
   assign stat.walk_done = (walk_ff >= cnt_ff);
   assign stat.wipe_done = (wipe_ff == bbfa_pkg::AddrW'(bbfa_pkg::MapWords - 1));
   assign stat.found = found_ff;
   assign stat.fit_ok = (cnt_ff != '0) && (cnt_ff <= len_ff);
endmodule
`default_nettype wire

/* sv/bbfa_control.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbfa_control: operation sequencer
// Steps the datapath through scan, mark, wipe and respond phases.
// ----------------------------------------------------------------------------
module bbfa_control (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_start,
   output logic                    busy,
   input  wire bbfa_pkg::stat_type stat,
   output bbfa_pkg::cmd_type       cmd
);
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DISP    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_MARK    = 3'd3;
   localparam logic [2:0] S_WIPE    = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;
   localparam logic [2:0] S_MARK_RD = 3'd6;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (stat.op)
               bbfa_pkg::OP_ALLOC:   state_in = stat.fit_ok ? S_SCAN : S_DONE;
               bbfa_pkg::OP_RELEASE: state_in = S_MARK_RD;
               bbfa_pkg::OP_CLEAR:   state_in = S_WIPE;
               default:              state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.scan_end = 1'b1;
               state_in = S_MARK_RD;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_MARK_RD: begin
            if (stat.walk_done || (stat.op == bbfa_pkg::OP_ALLOC && !stat.found)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            cmd.mark_val = (stat.op == bbfa_pkg::OP_ALLOC);
            state_in = S_MARK_RD;
         end
         S_WIPE: begin
            cmd.wipe = 1'b1;
            if (stat.wipe_done) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !cmd.finish) else $error("finish repeated");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy) else $error("load while busy");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy) else $error("not idle after finish");
endmodule
`default_nettype wire

/* sv/bitmap_best_fit_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_best_fit_allocator: best-fit block allocator over a used-block map
// Usage: raise req_start with operation, index and total while busy is low;
// the word is taken at that edge and busy rises. One result word appears
// on the rsp_ ports for a single cycle, marked by rsp_valid; the receiver
// cannot stall it. An allocate scans the map one bit a cycle up to the block
// count (held to at most 1024), then reads and sets each bit of the chosen
// run, skipping this if no run fits; a rejected allocate and a test only
// respond; a release reads and clears each bit from index on that lies below
// the block count; clear zeroes one map word a cycle. Busy falls at the edge
// that raises rsp_valid, so the next word can be taken at the edge after; one
// operation is in flight. csr_write loads block_count; the user must write it
// only while idle, as the block does not enforce it; values above 1024 act as
// 1024. Reset clears the map and sets block_count to 1024.
// ----------------------------------------------------------------------------
module bitmap_best_fit_allocator (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_write,
   input  wire [bbfa_pkg::CntW-1:0]     csr_data,
   input  wire                          req_start,
   output logic                         busy,
   input  wire [1:0]                    req_operation,
   input  wire [bbfa_pkg::IdxW-1:0]     req_block_index,
   input  wire [bbfa_pkg::CntW-1:0]     req_block_total,
   output logic                         rsp_valid,
   output logic                         rsp_success,
   output logic [bbfa_pkg::IdxW-1:0]    rsp_start_block,
   output logic                         rsp_bit_used
);
   bbfa_pkg::cmd_type  cmd;
   bbfa_pkg::stat_type stat;

   bbfa_control u_ctrl (
      .clock(clock), .reset(reset), .req_start(req_start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   bbfa_datapath u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_data(csr_data),
      .req_operation(req_operation), .req_block_index(req_block_index),
      .req_block_total(req_block_total), .cmd(cmd), .stat(stat),
      .rsp_valid(rsp_valid), .rsp_success(rsp_success),
      .rsp_start_block(rsp_start_block), .rsp_bit_used(rsp_bit_used)
   );
endmodule
`default_nettype wire

/* sim/bitmap_best_fit_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_best_fit_allocator_tb: self-checking bench for the best-fit allocator
// Drives allocate, release, test and clear words under several block counts,
// predicts each response from a local copy of the used map and compares it
// field by field as each response word is strobed out.
// ----------------------------------------------------------------------------
module bitmap_best_fit_allocator_tb;
   typedef struct packed {
      logic                       success;
      logic [bbfa_pkg::IdxW-1:0]  start_block;
      logic                       bit_used;
   } alloc_rsp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write = 1'b0;
   logic [bbfa_pkg::CntW-1:0]     csr_data = '0;
   logic                          req_start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_operation = bbfa_pkg::OP_TEST;
   logic [bbfa_pkg::IdxW-1:0]     req_block_index = '0;
   logic [bbfa_pkg::CntW-1:0]     req_block_total = '0;
   logic                          rsp_valid;
   logic                          rsp_success;
   logic [bbfa_pkg::IdxW-1:0]     rsp_start_block;
   logic                          rsp_bit_used;

   logic [bbfa_pkg::MaxBlocks-1:0] used_blocks = '0;
   int unsigned                    blocks_in_use = 1024;
   alloc_rsp_type                  pending_rsp[$];
   int                             error_count = 0;
   bit                             gaps_on = 1'b1;

   bitmap_best_fit_allocator dut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_data(csr_data),
      .req_start(req_start), .busy(busy), .req_operation(req_operation),
      .req_block_index(req_block_index), .req_block_total(req_block_total),
      .rsp_valid(rsp_valid), .rsp_success(rsp_success),
      .rsp_start_block(rsp_start_block), .rsp_bit_used(rsp_bit_used)
   );

   always #6 clock = ~clock;

   function automatic alloc_rsp_type predict_alloc(logic [1:0] op, int unsigned idx,
                                                   int unsigned cnt);
      alloc_rsp_type r;
      int unsigned   len, i, run_start, run_size, fit_start, fit_size;
      bit            found;
      r = '{success: 1'b1, start_block: '0, bit_used: 1'b0};
      len = (blocks_in_use > bbfa_pkg::MaxBlocks) ? bbfa_pkg::MaxBlocks : blocks_in_use;
      found = 1'b0;
      fit_start = 0;
      fit_size = 0;
      case (op)
         bbfa_pkg::OP_ALLOC: begin
            r.success = 1'b0;
            if (cnt != 0 && cnt <= len) begin
               i = 0;
               while (i < len) begin
                  while (i < len && used_blocks[i]) i++;
                  if (i >= len) break;
                  run_start = i;
                  run_size = 0;
                  while (i < len && !used_blocks[i]) begin
                     run_size++;
                     i++;
                  end
                  if (run_size >= cnt && (!found || run_size < fit_size)) begin
                     found = 1'b1;
                     fit_start = run_start;
                     fit_size = run_size;
                  end
               end
               if (found) begin
                  for (i = 0; i < cnt; i++) used_blocks[fit_start + i] = 1'b1;
                  r.success = 1'b1;
                  r.start_block = fit_start[bbfa_pkg::IdxW-1:0];
               end
            end
         end
         bbfa_pkg::OP_RELEASE:
            for (i = 0; i < cnt; i++)
               if (idx + i < len) used_blocks[idx + i] = 1'b0;
         bbfa_pkg::OP_TEST: r.bit_used = (idx < len) && used_blocks[idx];
         default: used_blocks = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response word success=%0b start=%0d used=%0b",
                     $time, rsp_success, rsp_start_block, rsp_bit_used);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_success !== want.success) begin
               $display("%0t: success expected %0b actual %0b", $time,
                        want.success, rsp_success);
               error_count++;
            end
            if (rsp_start_block !== want.start_block) begin
               $display("%0t: start_block expected %0d actual %0d", $time,
                        want.start_block, rsp_start_block);
               error_count++;
            end
            if (rsp_bit_used !== want.bit_used) begin
               $display("%0t: bit_used expected %0b actual %0b", $time,
                        want.bit_used, rsp_bit_used);
               error_count++;
            end
         end
      end
   end

   task automatic send_word(logic [1:0] op, int unsigned idx, int unsigned cnt);
      if (gaps_on)
         while ($urandom_range(99) < 37) @(posedge clock);
      req_start <= 1'b1;
      req_operation <= op;
      req_block_index <= idx[bbfa_pkg::IdxW-1:0];
      req_block_total <= cnt[bbfa_pkg::CntW-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(predict_alloc(op, idx, cnt));
      req_start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_and_set_count(int unsigned count);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= count[bbfa_pkg::CntW-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      blocks_in_use = count;
      @(posedge clock);
   endtask

   task automatic test_directed;
      send_word(bbfa_pkg::OP_ALLOC, 0, 0);
      send_word(bbfa_pkg::OP_ALLOC, 0, 1025);
      send_word(bbfa_pkg::OP_ALLOC, 1023, 1024);
      send_word(bbfa_pkg::OP_TEST, 1023, 0);
      send_word(bbfa_pkg::OP_ALLOC, 0, 1);
      send_word(bbfa_pkg::OP_RELEASE, 0, 1024);
      send_word(bbfa_pkg::OP_ALLOC, 0, 10);
      send_word(bbfa_pkg::OP_ALLOC, 0, 5);
      send_word(bbfa_pkg::OP_ALLOC, 0, 20);
      send_word(bbfa_pkg::OP_RELEASE, 10, 5);
      send_word(bbfa_pkg::OP_ALLOC, 0, 3);
      send_word(bbfa_pkg::OP_TEST, 11, 0);
      send_word(bbfa_pkg::OP_TEST, 14, 0);
      send_word(bbfa_pkg::OP_RELEASE, 1000, 2047);
      send_word(bbfa_pkg::OP_CLEAR, 1023, 2047);
      send_word(bbfa_pkg::OP_TEST, 0, 0);
   endtask

   task automatic test_shrunk_length;
      drain_and_set_count(1024);
      send_word(bbfa_pkg::OP_ALLOC, 0, 1000);
      drain_and_set_count(16);
      send_word(bbfa_pkg::OP_TEST, 20, 0);
      send_word(bbfa_pkg::OP_RELEASE, 4, 100);
      send_word(bbfa_pkg::OP_ALLOC, 0, 17);
      send_word(bbfa_pkg::OP_ALLOC, 0, 4);
      send_word(bbfa_pkg::OP_TEST, 5, 0);
      drain_and_set_count(1);
      send_word(bbfa_pkg::OP_ALLOC, 0, 1);
      send_word(bbfa_pkg::OP_TEST, 0, 0);
      drain_and_set_count(0);
      send_word(bbfa_pkg::OP_ALLOC, 0, 1);
      send_word(bbfa_pkg::OP_TEST, 0, 0);
      drain_and_set_count(2047);
      send_word(bbfa_pkg::OP_TEST, 999, 0);
      send_word(bbfa_pkg::OP_CLEAR, 0, 0);
   endtask

   task automatic test_random(int unsigned count, int unsigned words);
      int unsigned n, pick, idx, cnt;
      drain_and_set_count(count);
      for (n = 0; n < words; n++) begin
         pick = $urandom_range(99);
         idx = $urandom_range(1023);
         cnt = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(40);
         if (count >= 8 && $urandom_range(1) == 0) idx = $urandom_range(count - 1);
         if (pick < 45) send_word(bbfa_pkg::OP_ALLOC, idx, cnt);
         else if (pick < 75) send_word(bbfa_pkg::OP_RELEASE, idx, cnt);
         else if (pick < 97) send_word(bbfa_pkg::OP_TEST, idx, cnt);
         else send_word(bbfa_pkg::OP_CLEAR, idx, cnt);
      end
   endtask

   task automatic test_pause_until_drained;
      while (pending_rsp.size() != 0) @(posedge clock);
      send_word(bbfa_pkg::OP_ALLOC, $urandom_range(1023), $urandom_range(1, 30));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_shrunk_length();
      test_random(64, 150);
      test_pause_until_drained();
      gaps_on = 1'b0;
      test_random(200, 120);
      gaps_on = 1'b1;
      test_random(1024, 120);
      test_random(8, 100);
      test_random(1, 30);
      test_random(300, 120);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #200ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
